@@ hw/rtl/tmf_pkg.sv @@
`timescale 1ns / 1ps

package tmf_pkg;

    // Default build limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Register reset values
    localparam int         WIDTH_RESET     = 1024;
    localparam int         HEIGHT_RESET    = 1024;
    localparam logic [7:0] THRESHOLD_RESET = 8'd100;

    // Output pixel levels
    localparam logic [7:0] PIX_FOREGROUND = 8'd255;
    localparam logic [7:0] PIX_BACKGROUND = 8'd0;

    // Configuration port
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int THRESHOLD_W    = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = 2'd2;

    // Request kinds carried on tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Edge flags of one output window
    typedef struct packed {
        logic up;     // row above is inside the frame
        logic down;   // row below is inside the frame
        logic left;   // column to the left is inside the frame
        logic right;  // column to the right is inside the frame
        logic eof;    // last output pixel of the frame
    } tmf_win_t;

endpackage

@@ hw/rtl/threshold_majority_filter.sv @@
`timescale 1ns / 1ps
// A released result goes through stage 1, stage 2 and the output queue to m_axis.
// Throughput: one request per cycle while the output queue has room, set by the
//   single-pass window logic and the two read ports of each of the three bit line
//   stores; a 4-entry output queue absorbs m_axis stalls.
// Reset: rst_n clears positions, pointers, queue and restores register defaults;
//   the bit line stores are not cleared.
module threshold_majority_filter
    import tmf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel_value
    input  logic                  s_axis_tuser,   // [0] command

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] filtered_value
    output logic                  m_axis_tlast,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW         = $clog2(MAX_WIDTH + 3);
    localparam int W_RST      = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST      = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

    // Circular index reduction, input below twice the depth
    function automatic logic [HA_W-1:0] hist_wrap(input logic [HA_W:0] x);
        logic [HA_W:0] y;
        begin
            y = x - (HA_W+1)'(HIST_DEPTH);
            return (x >= (HA_W+1)'(HIST_DEPTH)) ? y[HA_W-1:0] : x[HA_W-1:0];
        end
    endfunction

    // Configuration registers
    logic [WW-1:0]          w_eff_reg;
    logic [COL_W-1:0]       w_last_reg;
    logic [ROW_W-1:0]       h_last_reg;
    logic [THRESHOLD_W-1:0] thr_reg;

    // Frame state
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [PW-1:0]    pending_reg, pending_next;
    logic [HA_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [HA_W-1:0]  rd_ptr_reg, rd_ptr_next;

    // Stage 1: store read request
    logic            rd_req_reg;
    logic [HA_W-1:0] addr_c_reg [3];
    logic [HA_W-1:0] addr_n_reg [3];
    tmf_win_t        meta1_reg;

    // Stage 2: window bits
    logic            v2_reg;
    tmf_win_t        meta2_reg;
    wire  [2:0]      col_c;
    wire  [2:0]      col_n;
    logic [2:0]      lcol_reg;

    // Output queue
    logic             fifo_bit_reg [FIFO_DEPTH];
    logic             fifo_eof_reg [FIFO_DEPTH];
    logic [FP_W-1:0]  fifo_wp_reg;
    logic [FP_W-1:0]  fifo_rp_reg;
    logic [FC_W-1:0]  fifo_cnt_reg;

    logic                      accept;
    logic                      pend_inc;
    logic                      pix_bit;
    logic [PW-1:0]             pend_new;
    logic [PW-1:0]             need1;
    logic                      at_col_end;
    logic                      last_row;
    logic                      emit;
    logic                      restart;
    logic                      pop;
    logic [FRAME_WIDTH_W-1:0]  cfg_w_raw;
    logic [FRAME_HEIGHT_W-1:0] cfg_h_raw;
    logic [WW-1:0]             cfg_w_eff;
    logic [HW-1:0]             cfg_h_eff;
    logic [HA_W:0]             ctr_ext;
    logic [HA_W:0]             w_ext;
    logic [HA_W:0]             up_base;
    logic [HA_W:0]             dn_base;
    logic [HA_W-1:0]           addr_c [3];
    logic [HA_W-1:0]           addr_n [3];
    tmf_win_t                  meta;
    logic [8:0]                pos_ok;
    logic [8:0]                pos_one;
    logic [2:0]                row_ok;
    logic [2:0]                col_ok;
    logic [3:0]                win_sum;
    logic [3:0]                win_cnt;
    logic                      maj_bit;
    logic [FC_W:0]             inflight;

    // Clamp register writes into the supported frame size
    always_comb
    begin
        cfg_w_raw = cfg_data[FRAME_WIDTH_W-1:0];
        cfg_h_raw = cfg_data[FRAME_HEIGHT_W-1:0];
        if (cfg_w_raw == '0)
            cfg_w_eff = WW'(1);
        else if (32'(cfg_w_raw) > MAX_WIDTH)
            cfg_w_eff = WW'(MAX_WIDTH);
        else
            cfg_w_eff = WW'(cfg_w_raw);
        if (cfg_h_raw == '0)
            cfg_h_eff = HW'(1);
        else if (32'(cfg_h_raw) > MAX_HEIGHT)
            cfg_h_eff = HW'(MAX_HEIGHT);
        else
            cfg_h_eff = HW'(cfg_h_raw);
    end

    assign restart = cfg_we && ((cfg_addr == REG_FRAME_WIDTH) || (cfg_addr == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg  <= WW'(W_RST);
            w_last_reg <= COL_W'(W_RST - 1);
            h_last_reg <= ROW_W'(H_RST - 1);
            thr_reg    <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:
                begin
                    w_eff_reg  <= cfg_w_eff;
                    w_last_reg <= COL_W'(cfg_w_eff - WW'(1));
                end
                REG_FRAME_HEIGHT:
                begin
                    h_last_reg <= ROW_W'(cfg_h_eff - HW'(1));
                end
                REG_THRESHOLD:
                begin
                    thr_reg <= cfg_data[THRESHOLD_W-1:0];
                end
                default:
                begin
                    // unused index, ignored
                end
            endcase
        end
    end

    // Request acceptance and release decision for the oldest pending output
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign pend_inc   = accept && (s_axis_tuser == CMD_PIXEL);
    assign pix_bit    = (s_axis_tdata >= thr_reg);
    assign pend_new   = pending_reg + PW'(pend_inc);
    assign at_col_end = (out_col_reg == w_last_reg);
    assign last_row   = (out_row_reg == h_last_reg);

    // Stored pixels the window still waits for, plus one
    always_comb
    begin
        if (last_row)
            need1 = at_col_end ? PW'(1) : PW'(2);
        else
            need1 = at_col_end ? PW'(w_eff_reg) + PW'(1) : PW'(w_eff_reg) + PW'(2);
    end

    assign emit = accept && (pend_new >= need1);

    always_comb
    begin
        pending_next = pend_new - PW'(emit);
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit)
        begin
            if (at_col_end)
            begin
                out_col_next = '0;
                out_row_next = last_row ? '0 : out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
        wr_ptr_next = pend_inc ? hist_wrap({1'b0, wr_ptr_reg} + (HA_W+1)'(1)) : wr_ptr_reg;
        rd_ptr_next = emit ? hist_wrap({1'b0, rd_ptr_reg} + (HA_W+1)'(1)) : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
        end
        else if (restart)
        begin
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            rd_ptr_reg  <= wr_ptr_reg;
        end
        else
        begin
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
        end
    end

    // Store addresses of the center column and the one to its right, rows above..below
    always_comb
    begin
        ctr_ext   = {1'b0, rd_ptr_reg};
        w_ext     = (HA_W+1)'(w_eff_reg);
        up_base   = ctr_ext + (HA_W+1)'(HIST_DEPTH) - w_ext;
        dn_base   = ctr_ext + w_ext;
        addr_c[0] = hist_wrap(up_base);
        addr_n[0] = hist_wrap(up_base + (HA_W+1)'(1));
        addr_c[1] = rd_ptr_reg;
        addr_n[1] = hist_wrap(ctr_ext + (HA_W+1)'(1));
        addr_c[2] = hist_wrap(dn_base);
        addr_n[2] = hist_wrap(dn_base + (HA_W+1)'(1));
        meta.up    = (out_row_reg != '0);
        meta.down  = !last_row;
        meta.left  = (out_col_reg != '0);
        meta.right = !at_col_end;
        meta.eof   = last_row && at_col_end;
    end

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_req_reg <= 1'b0;
        else
            rd_req_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int k = 0; k < 3; k++)
            begin
                addr_c_reg[k] <= addr_c[k];
                addr_n_reg[k] <= addr_n[k];
            end
            meta1_reg <= meta;
        end
    end

    // Three copies of the thresholded bit history, one per window row
    for (genvar k = 0; k < 3; k++)
    begin : g_row
        logic hist_mem [HIST_DEPTH];
        logic rd_c_reg;
        logic rd_n_reg;

        always_ff @(posedge clk)
        begin
            if (pend_inc)
                hist_mem[wr_ptr_reg] <= pix_bit;
            if (rd_req_reg)
            begin
                rd_c_reg <= hist_mem[addr_c_reg[k]];
                rd_n_reg <= hist_mem[addr_n_reg[k]];
            end
        end

        assign col_c[k] = rd_c_reg;
        assign col_n[k] = rd_n_reg;
    end

    // Stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= rd_req_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_req_reg)
            meta2_reg <= meta1_reg;
        // center column becomes the left column of the next output
        if (v2_reg)
            lcol_reg <= col_c;
    end

    // Vote over the in-frame window positions: one when ones reach half their count, rounded down
    always_comb
    begin
        row_ok = {meta2_reg.down, 1'b1, meta2_reg.up};
        col_ok = {meta2_reg.right, 1'b1, meta2_reg.left};
        for (int i = 0; i < 3; i++)
        begin
            pos_ok[3*i]     = row_ok[i] & col_ok[0];
            pos_ok[3*i + 1] = row_ok[i] & col_ok[1];
            pos_ok[3*i + 2] = row_ok[i] & col_ok[2];
            pos_one[3*i]     = pos_ok[3*i]     & lcol_reg[i];
            pos_one[3*i + 1] = pos_ok[3*i + 1] & col_c[i];
            pos_one[3*i + 2] = pos_ok[3*i + 2] & col_n[i];
        end
        win_sum = 4'($countones(pos_ok));
        win_cnt = 4'($countones(pos_one));
        maj_bit = (win_cnt >= (win_sum >> 1));
    end

    // Output queue
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            fifo_bit_reg[fifo_wp_reg] <= maj_bit;
            fifo_eof_reg[fifo_wp_reg] <= meta2_reg.eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wp_reg  <= '0;
            fifo_rp_reg  <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (v2_reg)
                fifo_wp_reg <= fifo_wp_reg + FP_W'(1);
            if (pop)
                fifo_rp_reg <= fifo_rp_reg + FP_W'(1);
            fifo_cnt_reg <= fifo_cnt_reg + FC_W'(v2_reg) - FC_W'(pop);
        end
    end

    // Accept only while the queue can hold every result still in flight
    assign inflight      = {1'b0, fifo_cnt_reg} + (FC_W+1)'(rd_req_reg) + (FC_W+1)'(v2_reg);
    assign s_axis_tready = (inflight < (FC_W+1)'(FIFO_DEPTH));

    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = fifo_bit_reg[fifo_rp_reg] ? PIX_FOREGROUND : PIX_BACKGROUND;
    assign m_axis_tlast  = fifo_eof_reg[fifo_rp_reg];

    // Checks
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !pop) |-> (fifo_cnt_reg < FC_W'(FIFO_DEPTH)))
        else $error("output queue overflow");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (PW+1)'(pending_reg) <= (PW+1)'(w_eff_reg) + (PW+1)'(1))
        else $error("pending output count beyond one row plus one");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        hist_wrap({1'b0, rd_ptr_reg} + (HA_W+1)'(pending_reg)) == wr_ptr_reg)
        else $error("history read pointer out of step with write pointer");

endmodule
